/* rtl/core/ffba_pkg.sv */
package ffba_pkg;

  // Heap table geometry
  localparam int MaxBlocks   = 64;
  localparam int IdxW        = $clog2(MaxBlocks);
  localparam int CntW        = $clog2(MaxBlocks + 1);
  localparam int HeaderBytes = 24;
  // Alignment is a power of two; rounding is done with a mask
  localparam int AlignBytes  = 16;
  localparam logic [32:0] AlignLow  = 33'(AlignBytes - 1);
  localparam logic [32:0] AlignMask = ~AlignLow;

  // Configuration registers
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgHeapBase  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgHeapLimit = CfgIdxW'(1);
  localparam logic [31:0] HeapBaseReset  = 32'd0;
  localparam logic [31:0] HeapLimitReset = 32'd1048576;

  // Request actions
  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  // Response status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoMem   = 2'd1;
  localparam logic [1:0] StatusBadAddr = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] request_size;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StScan,
    StAppend,
    StCommit,
    StResp
  } state_e;

  typedef enum logic [2:0] {
    ResNone,
    ResNullOk,
    ResUnknown,
    ResHit,
    ResAppend
  } res_sel_e;

  typedef struct packed {
    logic     load_req;
    logic     prep;
    logic     scan_step;
    logic     calc_end;
    logic     load_out;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic null_addr;
    logic count_zero;
    logic cmp_vld;
    logic match;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/first_fit_block_allocator_top.sv */
// channel | dir | handshake           | payload
// in      | in  | in_valid_i/in_stall_o   | in_req_i  (ffba_pkg::req_t)
// out     | out | out_valid_o/out_stall_i | out_rsp_o (ffba_pkg::rsp_t)
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request at a time. An allocation miss goes through prep, a scan with one
// table read per entry, append, commit and response.
// Reset clears the block count, sets break to heap base, loads the config
// defaults; table contents are not cleared. A stalled response sits in the
// output register while the next request is accepted and worked on.
module first_fit_block_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ffba_pkg::req_t                in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ffba_pkg::rsp_t                out_rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffba_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffba_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted but controller not busy");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != ffba_pkg::StatusOk) |->
      (out_rsp_o.result_address == 32'd0))
    else $error("failed response carries an address");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free && in_stall_o)
    else $error("response loaded over a held result");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_req, cmd.prep, cmd.scan_step, cmd.calc_end, cmd.load_out}))
    else $error("controller issued conflicting commands");
`endif

endmodule

/* rtl/core/ffba_ctrl.sv */
module ffba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ffba_pkg::sts_t sts_i,
  output ffba_pkg::cmd_t cmd_o
);

  ffba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffba_pkg::StIdle: begin
        if (in_valid_i) state_d = ffba_pkg::StPrep;
      end
      ffba_pkg::StPrep: begin
        if (sts_i.is_free && sts_i.null_addr) begin
          state_d = ffba_pkg::StResp;
        end else if (sts_i.count_zero) begin
          state_d = sts_i.is_free ? ffba_pkg::StResp : ffba_pkg::StAppend;
        end else begin
          state_d = ffba_pkg::StScan;
        end
      end
      ffba_pkg::StScan: begin
        if (sts_i.cmp_vld && sts_i.match) begin
          state_d = ffba_pkg::StResp;
        end else if (sts_i.scan_last) begin
          state_d = sts_i.is_free ? ffba_pkg::StResp : ffba_pkg::StAppend;
        end
      end
      ffba_pkg::StAppend: state_d = ffba_pkg::StCommit;
      ffba_pkg::StCommit: state_d = ffba_pkg::StResp;
      ffba_pkg::StResp: begin
        if (sts_i.out_free) state_d = ffba_pkg::StIdle;
      end
      default: state_d = ffba_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.res_sel = ffba_pkg::ResNone;
    in_stall_o    = 1'b1;
    case (state_q)
      ffba_pkg::StIdle: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = in_valid_i;
      end
      ffba_pkg::StPrep: begin
        cmd_o.prep = 1'b1;
        if (sts_i.is_free && sts_i.null_addr) begin
          cmd_o.res_sel = ffba_pkg::ResNullOk;
        end else if (sts_i.count_zero && sts_i.is_free) begin
          cmd_o.res_sel = ffba_pkg::ResUnknown;
        end
      end
      ffba_pkg::StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.cmp_vld && sts_i.match) begin
          cmd_o.res_sel = ffba_pkg::ResHit;
        end else if (sts_i.scan_last && sts_i.is_free) begin
          cmd_o.res_sel = ffba_pkg::ResUnknown;
        end
      end
      ffba_pkg::StAppend: cmd_o.calc_end = 1'b1;
      ffba_pkg::StCommit: cmd_o.res_sel = ffba_pkg::ResAppend;
      ffba_pkg::StResp:   cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/core/ffba_dp.sv */
module ffba_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffba_pkg::req_t                in_req_i,
  input  logic                          cfg_valid_i,
  input  logic [ffba_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output ffba_pkg::rsp_t                out_rsp_o,
  input  ffba_pkg::cmd_t                cmd_i,
  output ffba_pkg::sts_t                sts_o
);

  localparam logic [ffba_pkg::CntW-1:0] CntMax = ffba_pkg::CntW'(ffba_pkg::MaxBlocks);
  localparam logic [ffba_pkg::CntW-1:0] CntOne = ffba_pkg::CntW'(1);
  localparam logic [32:0] Hdr33 = 33'(ffba_pkg::HeaderBytes);
  localparam logic [33:0] Hdr34 = 34'(ffba_pkg::HeaderBytes);

  ffba_pkg::req_t req_q;
  logic [31:0] heap_limit_q;
  logic [31:0] break_q, break_d;
  logic [ffba_pkg::CntW-1:0] count_q, count_d;
  logic [32:0] asz_q, base_q;
  logic [33:0] end_q;
  logic [ffba_pkg::CntW-1:0] rd_idx_q, cmp_idx_q;
  logic cmp_vld_q;
  ffba_pkg::entry_t rdata_q;
  ffba_pkg::rsp_t pend_q, pend_d;
  logic out_valid_q;
  ffba_pkg::rsp_t out_q;

  ffba_pkg::entry_t mem [ffba_pkg::MaxBlocks];
  logic mem_we;
  logic [ffba_pkg::IdxW-1:0] mem_waddr;
  ffba_pkg::entry_t mem_wdata;

  logic issue, match, append_ok, base_wr;
  logic [32:0] hit_addr;

  assign issue     = cmd_i.scan_step && (rd_idx_q < count_q);
  assign hit_addr  = {1'b0, rdata_q.start} + Hdr33;
  assign match     = (req_q.action == ffba_pkg::ActFree)
                   ? (hit_addr == {1'b0, req_q.release_address})
                   : (rdata_q.free && ({1'b0, rdata_q.size} >= asz_q));
  assign append_ok = (count_q < CntMax) && (end_q <= {2'b00, heap_limit_q});
  assign base_wr   = cfg_valid_i && (cfg_index_i == ffba_pkg::CfgHeapBase);

  always_comb begin
    sts_o.is_free    = (req_q.action == ffba_pkg::ActFree);
    sts_o.null_addr  = (req_q.release_address == 32'd0);
    sts_o.count_zero = (count_q == '0);
    sts_o.cmp_vld    = cmp_vld_q;
    sts_o.match      = match;
    sts_o.scan_last  = cmp_vld_q && !match && ((cmp_idx_q + CntOne) == count_q);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // result, table write and break/count update
  always_comb begin
    pend_d    = pend_q;
    count_d   = count_q;
    break_d   = break_q;
    mem_we    = 1'b0;
    mem_waddr = cmp_idx_q[ffba_pkg::IdxW-1:0];
    mem_wdata = rdata_q;
    case (cmd_i.res_sel)
      ffba_pkg::ResNullOk: pend_d = '{result_address: 32'd0, status: ffba_pkg::StatusOk};
      ffba_pkg::ResUnknown: begin
        pend_d = '{result_address: 32'd0, status: ffba_pkg::StatusBadAddr};
      end
      ffba_pkg::ResHit: begin
        mem_we         = 1'b1;
        mem_wdata.free = sts_o.is_free;
        pend_d.status  = ffba_pkg::StatusOk;
        pend_d.result_address = sts_o.is_free ? 32'd0 : hit_addr[31:0];
      end
      ffba_pkg::ResAppend: begin
        if (append_ok) begin
          mem_we    = 1'b1;
          mem_waddr = count_q[ffba_pkg::IdxW-1:0];
          mem_wdata = '{start: base_q[31:0], size: asz_q[31:0], free: 1'b0};
          count_d   = count_q + CntOne;
          break_d   = end_q[31:0];
          pend_d.result_address = 32'(base_q + Hdr33);
          pend_d.status         = ffba_pkg::StatusOk;
        end else begin
          pend_d = '{result_address: 32'd0, status: ffba_pkg::StatusNoMem};
        end
      end
      default: ;
    endcase
    // heap base moves the break only while the table is empty
    if (base_wr && (count_q == '0)) break_d = cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= ffba_pkg::HeapLimitReset;
      break_q      <= ffba_pkg::HeapBaseReset;
      count_q      <= '0;
      rd_idx_q     <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      break_q <= break_d;
      count_q <= count_d;
      if (cfg_valid_i && (cfg_index_i == ffba_pkg::CfgHeapLimit)) heap_limit_q <= cfg_data_i;
      if (cmd_i.prep) begin
        rd_idx_q  <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_vld_q <= issue;
        cmp_idx_q <= rd_idx_q;
        if (issue) rd_idx_q <= rd_idx_q + CntOne;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= in_req_i;
    if (cmd_i.prep) begin
      asz_q  <= ({1'b0, req_q.request_size} + ffba_pkg::AlignLow) & ffba_pkg::AlignMask;
      base_q <= ({1'b0, break_q} + ffba_pkg::AlignLow) & ffba_pkg::AlignMask;
    end
    if (cmd_i.calc_end) end_q <= {1'b0, base_q} + Hdr34 + {1'b0, asz_q};
    pend_q <= pend_d;
    if (cmd_i.load_out) out_q <= pend_q;
  end

  // block table: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (issue) rdata_q <= mem[rd_idx_q[ffba_pkg::IdxW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import ffba_pkg::*;

  // Heap predictor plus queue of responses still owed by the block
  class heap_scoreboard;
    logic [31:0] base_reg;
    logic [31:0] limit_reg;
    logic [31:0] blk_start [MaxBlocks];
    logic [31:0] blk_size [MaxBlocks];
    bit          blk_free [MaxBlocks];
    int unsigned blk_count;
    logic [31:0] brk;
    rsp_t        awaited_rsp [$];
    int unsigned mismatches;

    function new();
      base_reg   = HeapBaseReset;
      limit_reg  = HeapLimitReset;
      blk_count  = 0;
      brk        = HeapBaseReset;
      mismatches = 0;
    endfunction

    function longint unsigned align_up(input longint unsigned v);
      return ((v + AlignBytes - 1) / AlignBytes) * AlignBytes;
    endfunction

    function void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
      if (idx == CfgHeapBase) begin
        base_reg = val;
        // break only follows the base while nothing has been carved out
        if (blk_count == 0) brk = val;
      end else if (idx == CfgHeapLimit) begin
        limit_reg = val;
      end
    endfunction

    function rsp_t serve_request(input req_t r);
      rsp_t            o;
      longint unsigned need;
      longint unsigned hdr;
      longint unsigned top;
      int unsigned     i;
      o.result_address = '0;
      o.status         = StatusOk;
      if (r.action == ActAlloc) begin
        need = align_up(longint'(r.request_size));
        for (i = 0; i < blk_count; i++) begin
          if (blk_free[i] && blk_size[i] >= need) begin
            blk_free[i]      = 1'b0;
            o.result_address = blk_start[i] + 32'(HeaderBytes);
            return o;
          end
        end
        hdr = align_up(longint'(brk));
        top = hdr + HeaderBytes + need;
        if (blk_count >= MaxBlocks || top > limit_reg) begin
          o.status = StatusNoMem;
        end else begin
          blk_start[blk_count] = 32'(hdr);
          blk_size[blk_count]  = 32'(need);
          blk_free[blk_count]  = 1'b0;
          blk_count++;
          brk              = 32'(top);
          o.result_address = 32'(hdr + HeaderBytes);
        end
      end else if (r.release_address != '0) begin
        o.status = StatusBadAddr;
        // lowest index wins
        for (i = 0; i < blk_count; i++) begin
          if (o.status == StatusBadAddr &&
              {32'd0, blk_start[i]} + 64'(HeaderBytes) == {32'd0, r.release_address}) begin
            blk_free[i] = 1'b1;
            o.status    = StatusOk;
          end
        end
      end
      return o;
    endfunction

    function void note_request(input req_t r);
      awaited_rsp.push_back(serve_request(r));
    endfunction

    task report_mismatch(input string msg);
      $display("%0t MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    task check_response(input rsp_t got);
      rsp_t want;
      if (awaited_rsp.size() == 0) begin
        report_mismatch($sformatf("unexpected response addr=%h status=%0d",
                                  got.result_address, got.status));
      end else begin
        want = awaited_rsp.pop_front();
        if (got.result_address !== want.result_address)
          report_mismatch($sformatf("result_address got %h want %h",
                                    got.result_address, want.result_address));
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      end
    endtask
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  req_t                 in_req_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  rsp_t                 out_rsp_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [31:0]          cfg_data_i  = '0;

  heap_scoreboard sb = new();
  bit             quiet = 1'b0;
  int unsigned    stall_hold = 0;

  first_fit_block_allocator_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // response side backpressure: random stall bursts with random gaps between them
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_hold = $urandom_range(0, 30);
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_hold = $urandom_range(0, 14);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
  end

  function automatic req_t alloc_req(input logic [31:0] sz);
    req_t r;
    r.action          = ActAlloc;
    r.request_size    = sz;
    r.release_address = $urandom();
    return r;
  endfunction

  function automatic req_t free_req(input logic [31:0] addr);
    req_t r;
    r.action          = ActFree;
    r.request_size    = $urandom();
    r.release_address = addr;
    return r;
  endfunction

  function automatic logic [31:0] block_addr(input int unsigned i);
    return sb.blk_start[i] + 32'(HeaderBytes);
  endfunction

  function automatic logic [31:0] pick_size();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return $urandom_range(0, 256);
    if (sel < 70 && sb.blk_count != 0)
      return sb.blk_size[$urandom_range(0, sb.blk_count - 1)] - $urandom_range(0, 15);
    if (sel < 80) return $urandom_range(257, 4096);
    if (sel < 87) return 32'd0;
    if (sel < 93) return 32'hFFFF_FFF0 + $urandom_range(0, 15);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_release();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sb.blk_count != 0) begin
      if (sel < 70) return block_addr($urandom_range(0, sb.blk_count - 1));
      // lands between data addresses, never on one
      if (sel < 80) return block_addr($urandom_range(0, sb.blk_count - 1)) +
                           $urandom_range(1, 23);
    end
    if (sel < 90) return 32'd0;
    return $urandom();
  endfunction

  task automatic push_request(input req_t r);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.awaited_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.apply_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) begin
      sender_gap();
      if ($urandom_range(0, 1) == 1) push_request(free_req(pick_release()));
      else push_request(alloc_req(pick_size()));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table: limit and alignment failures leave the break untouched
    write_reg(CfgHeapLimit, 32'd0);
    push_request(alloc_req(32'd0));
    push_request(free_req(32'd0));
    push_request(free_req(32'hFFFF_FFFF));
    write_reg(CfgHeapBase, 32'hFFFF_FFFF);
    write_reg(CfgHeapLimit, 32'hFFFF_FFFF);
    push_request(alloc_req(32'd0));
    push_request(alloc_req(32'hFFFF_FFFF));

    // unaligned base, then reuse / double free / zero size
    write_reg(CfgHeapBase, 32'h0000_1003);
    write_reg(CfgHeapLimit, HeapLimitReset);
    push_request(alloc_req(32'd0));
    push_request(alloc_req(32'd1));
    push_request(alloc_req(32'hFFFF_FFF1));
    push_request(alloc_req(32'd100));
    push_request(free_req(block_addr(1)));
    push_request(free_req(block_addr(1)));
    push_request(alloc_req(32'd0));
    push_request(free_req(block_addr(0)));
    push_request(alloc_req(32'd1));
    push_request(free_req(block_addr(2) + 32'd8));
    push_request(free_req(block_addr(2)));
    write_reg(CfgHeapBase, 32'd0);
    push_request(alloc_req(32'd16));
    // limit lands exactly on the end of the next append
    write_reg(CfgHeapLimit, 32'(sb.align_up(longint'(sb.brk)) + HeaderBytes + 32));
    push_request(alloc_req(32'd32));
    push_request(alloc_req(32'd1));

    write_reg(CfgHeapBase, 32'hFFFF_FFFF);
    write_reg(CfgHeapLimit, sb.brk + 32'd3000);
    run_random(250);
    write_reg(CfgHeapLimit, 32'hFFFF_FFFF);
    run_random(400);
    write_reg(CfgHeapBase, 32'd0);
    write_reg(CfgHeapLimit, 32'd0);
    run_random(250);
    write_reg(CfgHeapBase, $urandom());
    write_reg(CfgHeapLimit, $urandom());
    run_random(250);
    write_reg(CfgHeapLimit, HeapLimitReset);
    quiet = 1'b1;
    run_random(180);

    drain();
    repeat (MaxBlocks + 16) @(posedge clk_i);
    if (sb.awaited_rsp.size() != 0)
      sb.report_mismatch($sformatf("%0d responses never arrived", sb.awaited_rsp.size()));
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ffba_pkg.sv
rtl/core/ffba_ctrl.sv
rtl/core/ffba_dp.sv
rtl/core/first_fit_block_allocator_top.sv
tb/sv/testbench.sv
